// ===== design/fsgs_pkg.sv =====
package fsgs_pkg;

    // operation codes of the input transaction
    localparam logic [1:0] OP_STEP  = 2'd0;
    localparam logic [1:0] OP_SPAWN = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // tie-break lfsr
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [15:0] SEED_RESET = 16'd44257;

    // register map, word index taken from paddr[2]
    localparam logic REG_RANDOM_SEED = 1'b0;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL_RD,
        S_CELL_EXE,
        S_STEP_FIRST,
        S_STEP_CUR,
        S_STEP_BELOW,
        S_SCAN,
        S_ROW_END,
        S_DONE
    } state_t;

endpackage

// ===== design/falling_sand_grid_step.sv =====
// Falling-sand grid of GRID_WIDTH x GRID_HEIGHT one-bit cells, held in a row-wide memory
// (one row per word). One transaction is taken at a time and gives one result. A step scans
// the grid one cell per cycle through a single shared move-decision unit, with a row load and
// a write-back around each row. A spawn is a read-modify-write of one row; a read only reads it.
// After reset the block sweeps the memory to empty, one row per cycle, before s_ready rises;
// the random_seed register can be written during that sweep.
module falling_sand_grid_step
    import fsgs_pkg::*;
#(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [5:0]  s_cell_col,
    input  logic [5:0]  s_cell_row,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_cell_occupied,
    output logic        m_grain_placed
);

    localparam int COL_W = $clog2(GRID_WIDTH);
    localparam int ROW_W = $clog2(GRID_HEIGHT);

    typedef logic [GRID_WIDTH-1:0] row_t;

    // row memory
    row_t sand_mem [GRID_HEIGHT];
    row_t rd_data_reg;

    state_t state_reg, state_next;

    logic [15:0]      seed_reg;
    logic [15:0]      lfsr_reg;
    logic [1:0]       op_reg;
    logic [COL_W-1:0] col_idx_reg;
    logic [ROW_W-1:0] row_idx_reg;
    logic             inb_reg;
    logic [COL_W-1:0] c_reg;
    logic [ROW_W-1:0] r_reg;
    row_t             cur_reg;
    row_t             below_reg;
    row_t             moved_reg;
    row_t             set_cur_reg;
    row_t             set_next_reg;
    logic             res_occ_reg;
    logic             res_placed_reg;
    logic             m_valid_reg;
    logic             m_cell_occupied_reg;
    logic             m_grain_placed_reg;

    logic             mem_we;
    logic [ROW_W-1:0] mem_waddr;
    logic [ROW_W-1:0] mem_raddr;
    row_t             mem_wdata;

    logic             cfg_wr;
    logic             s_accept;
    logic             in_bounds;
    logic             r_last;
    logic             c_last;
    logic [ROW_W:0]   row_plus1;
    logic [ROW_W:0]   row_plus2;
    logic             below_valid;

    // move decision unit
    logic             has_left;
    logic             has_right;
    logic [COL_W-1:0] col_l;
    logic [COL_W-1:0] col_r;
    logic             empty_c;
    logic             empty_l;
    logic             empty_r;
    logic             do_move;
    logic             use_tie;
    logic [COL_W-1:0] tgt_col;
    logic [15:0]      lfsr_adv;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_RANDOM_SEED);
    assign prdata   = (paddr[2] == REG_RANDOM_SEED) ? {16'd0, seed_reg} : 32'd0;
    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign in_bounds = (32'(s_cell_col) < GRID_WIDTH) && (32'(s_cell_row) < GRID_HEIGHT);

    assign r_last      = (r_reg == ROW_W'(GRID_HEIGHT - 1));
    assign c_last      = (c_reg == COL_W'(GRID_WIDTH - 1));
    assign row_plus1   = {1'b0, r_reg} + (ROW_W+1)'(1);
    assign row_plus2   = {1'b0, r_reg} + (ROW_W+1)'(2);
    assign below_valid = (32'(row_plus1) < GRID_HEIGHT);

    assign lfsr_adv = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : 16'd0);

    // neighbors of the current cell in the row below; out of bounds reads as full
    always_comb begin
        has_left  = (c_reg != '0);
        has_right = !c_last;
        col_l     = c_reg - COL_W'(1);
        col_r     = c_reg + COL_W'(1);
        empty_c   = !below_reg[c_reg];
        empty_l   = has_left && !below_reg[col_l];
        empty_r   = has_right && !below_reg[col_r];
        do_move   = 1'b0;
        use_tie   = 1'b0;
        tgt_col   = c_reg;
        if (cur_reg[c_reg]) begin
            priority if (empty_c) begin
                do_move = 1'b1;
                tgt_col = c_reg;
            end else if (empty_l && empty_r) begin
                do_move = 1'b1;
                use_tie = 1'b1;
                tgt_col = lfsr_reg[0] ? col_l : col_r;
            end else if (empty_r) begin
                do_move = 1'b1;
                tgt_col = col_r;
            end else if (empty_l) begin
                do_move = 1'b1;
                tgt_col = col_l;
            end else begin
                // blocked grain stays put
                do_move = 1'b0;
            end
        end
    end

    // sequencer next state and memory controls
    always_comb begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = r_reg;
        mem_wdata  = '0;
        mem_raddr  = r_reg;
        unique case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    if (s_operation == OP_STEP) begin
                        state_next = S_STEP_FIRST;
                    end else if (s_operation == OP_SPAWN || s_operation == OP_READ) begin
                        state_next = S_CELL_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CELL_RD: begin
                mem_raddr  = row_idx_reg;
                state_next = S_CELL_EXE;
            end
            S_CELL_EXE: begin
                mem_waddr = row_idx_reg;
                mem_wdata = rd_data_reg | (row_t'(1) << col_idx_reg);
                mem_we    = (op_reg == OP_SPAWN) && inb_reg && !rd_data_reg[col_idx_reg];
                state_next = S_DONE;
            end
            S_STEP_FIRST: begin
                mem_raddr  = '0;
                state_next = S_STEP_CUR;
            end
            S_STEP_CUR: begin
                mem_raddr  = ROW_W'(1);
                state_next = S_STEP_BELOW;
            end
            S_STEP_BELOW: begin
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (c_last) begin
                    state_next = S_ROW_END;
                end
            end
            S_ROW_END: begin
                mem_we    = 1'b1;
                mem_wdata = (cur_reg & ~moved_reg) | set_cur_reg;
                mem_raddr = row_plus2[ROW_W-1:0];
                state_next = r_last ? S_DONE : S_STEP_BELOW;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // grid memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sand_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= sand_mem[mem_raddr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            r_reg       <= '0;
            c_reg       <= '0;
            seed_reg    <= SEED_RESET;
            lfsr_reg    <= SEED_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // row and column counters
            unique case (state_reg)
                S_CLEAR:      r_reg <= r_reg + ROW_W'(1);
                S_IDLE:       r_reg <= '0;
                S_STEP_BELOW: c_reg <= '0;
                S_SCAN:       c_reg <= c_reg + COL_W'(1);
                S_ROW_END:    r_reg <= r_reg + ROW_W'(1);
                default: ;
            endcase

            // seed write reloads the lfsr, otherwise ties advance it
            if (cfg_wr) begin
                seed_reg <= pwdata[15:0];
                lfsr_reg <= pwdata[15:0];
            end else if (state_reg == S_SCAN && use_tie) begin
                lfsr_reg <= lfsr_adv;
            end

            // result register
            if (state_reg == S_DONE && !m_valid_reg) begin
                m_valid_reg <= 1'b1;
            end else if (state_reg == S_DONE) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg         <= s_operation;
            col_idx_reg    <= COL_W'(s_cell_col);
            row_idx_reg    <= ROW_W'(s_cell_row);
            inb_reg        <= in_bounds;
            res_occ_reg    <= 1'b0;
            res_placed_reg <= 1'b0;
        end

        unique case (state_reg)
            S_CELL_EXE: begin
                res_occ_reg    <= (op_reg == OP_READ) && inb_reg && rd_data_reg[col_idx_reg];
                res_placed_reg <= mem_we;
            end
            S_STEP_CUR: begin
                cur_reg      <= rd_data_reg;
                moved_reg    <= '0;
                set_cur_reg  <= '0;
                set_next_reg <= '0;
            end
            S_STEP_BELOW: begin
                below_reg <= below_valid ? rd_data_reg : '1;
            end
            S_SCAN: begin
                if (do_move) begin
                    moved_reg[c_reg]      <= 1'b1;
                    set_next_reg[tgt_col] <= 1'b1;
                end
            end
            S_ROW_END: begin
                cur_reg      <= below_reg;
                set_cur_reg  <= set_next_reg;
                set_next_reg <= '0;
                moved_reg    <= '0;
            end
            default: ;
        endcase

        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_cell_occupied_reg <= res_occ_reg;
            m_grain_placed_reg  <= res_placed_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cell_occupied = m_cell_occupied_reg;
    assign m_grain_placed  = m_grain_placed_reg;

endmodule

// ===== design/fsgs_chk.sv =====
module fsgs_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_cell_occupied,
    input logic        m_grain_placed
);

    // a stalled result transaction holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_occupied) && $stable(m_grain_placed))
        else $error("result changed while stalled");

    // a result never reports both a read hit and a placement
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_cell_occupied && m_grain_placed))
        else $error("both result fields set");

    // the block is busy right after taking a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after acceptance");

    // reset empties the result channel
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind falling_sand_grid_step fsgs_chk u_fsgs_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_cell_occupied (m_cell_occupied),
    .m_grain_placed  (m_grain_placed)
);
